// ----- hw/rtl/weighted_leader_clustering_assert.svh -----
// assertion macros shared by the checker
`ifndef WEIGHTED_LEADER_CLUSTERING_ASSERT_SVH
`define WEIGHTED_LEADER_CLUSTERING_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wlc check failed");

// next-cycle implication, disabled in reset
`define WLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wlc check failed");

`endif

// ----- hw/rtl/wlc_pkg.sv -----
// shared types and constants for the leader clustering block
package wlc_pkg;
  localparam int PT_W    = 24;
  localparam int WGT_W   = 16;
  localparam int THR_W   = 32;
  localparam int CNT_W   = 16;
  localparam int SQ_W    = 52;
  localparam int RT_W    = 26;
  localparam int MUL_W   = 27;
  localparam int PRD_W   = 54;
  localparam int NUM_W   = 42;
  localparam int IDX_W   = 6;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 32;
  localparam int LDR_W   = 5 * PT_W;
  localparam int MEAN_W  = 3 * PT_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  localparam logic [CFG_IW-1:0] CFG_WDIST  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WLEN   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WBEND  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_THRESH = 2'd3;

  typedef logic signed [PT_W-1:0] pt_t;
  typedef logic [PT_W-1:0] mag_t;
endpackage

// ----- hw/rtl/wlc_if.sv -----
// request channels for items and results
interface wlc_in_if import wlc_pkg::*; ();
  logic valid;
  logic ready;
  logic first_in_set;
  pt_t  start_x;
  pt_t  start_y;
  pt_t  start_z;
  mag_t curve_length;
  mag_t curve_bend;
  modport source (output valid, first_in_set, start_x, start_y, start_z, curve_length,
                  curve_bend, input ready);
  modport sink (input valid, first_in_set, start_x, start_y, start_z, curve_length,
                curve_bend, output ready);
endinterface

interface wlc_out_if import wlc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cluster_index;
  logic             created_new;
  logic             table_full;
  logic [CNT_W-1:0] member_count;
  pt_t              center_x;
  pt_t              center_y;
  pt_t              center_z;
  modport source (output valid, cluster_index, created_new, table_full, member_count,
                  center_x, center_y, center_z, input ready);
  modport sink (input valid, cluster_index, created_new, table_full, member_count,
                center_x, center_y, center_z, output ready);
endinterface

// ----- hw/rtl/wlc_ram.sv -----
// generic single-port-write ram with registered read
module wlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/wlc_isqrt.sv -----
// iterative integer square root, one root bit per cycle
module wlc_isqrt import wlc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] radicand,
  output logic            done,
  output logic [RT_W-1:0] root
);
  localparam int REM_W = RT_W + 2;

  logic [SQ_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [RT_W-1:0]  root_r, root_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ----- hw/rtl/wlc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module wlc_div import wlc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);
  localparam int REM_W = CNT_W + 1;

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W-1:0] rem_sh;

  assign rem_sh = {rem_r[REM_W-2:0], q_r[NUM_W-1]};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// ----- hw/rtl/weighted_leader_clustering.sv -----
// leader clustering top: sequencer, shared multiplier, cluster tables
// per cluster scanned: leader read, squared distances summed, square root, weighted sum,
// threshold compare; then open a slot or report overflow, or join (three mean divides)
// one item at a time: in ready only while idle, in the cycle after the result is loaded;
// a result still waiting in the output register holds the sequencer in its last state
// reset (synchronous, active low) empties the table and loads default weights
module weighted_leader_clustering import wlc_pkg::*; #(
  parameter int MAX_CLUSTERS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  wlc_in_if.sink            in_ch,
  wlc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);
  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CW = $clog2(MAX_CLUSTERS + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_SQ0  = 4'd2;
  localparam logic [3:0] ST_SQ1  = 4'd3;
  localparam logic [3:0] ST_SQ2  = 4'd4;
  localparam logic [3:0] ST_SQ3  = 4'd5;
  localparam logic [3:0] ST_SQRT = 4'd6;
  localparam logic [3:0] ST_W0   = 4'd7;
  localparam logic [3:0] ST_W1   = 4'd8;
  localparam logic [3:0] ST_W2   = 4'd9;
  localparam logic [3:0] ST_W3   = 4'd10;
  localparam logic [3:0] ST_CMP  = 4'd11;
  localparam logic [3:0] ST_HWT  = 4'd12;
  localparam logic [3:0] ST_M0   = 4'd13;
  localparam logic [3:0] ST_M1   = 4'd14;
  localparam logic [3:0] ST_MDIV = 4'd15;
  // states past the four-bit ones share a fifth vector bit
  localparam logic [4:0] ST_WR   = 5'd16;
  localparam logic [4:0] ST_NEW  = 5'd17;
  localparam logic [4:0] ST_FIN  = 5'd18;

  logic [4:0] state_r;

  logic [WGT_W-1:0] wd_r, wl_r, wc_r;
  logic [THR_W-1:0] thr_r;

  pt_t  px_r, py_r, pz_r;
  mag_t len_r, bend_r;

  logic [CW-1:0] idx_r, used_r;
  logic [1:0]    ax_r;
  logic [PRD_W-1:0] acc_r;
  logic signed [PRD_W-1:0] prod_r;
  logic [CNT_W-1:0] n_r;
  logic             sign_r;

  logic [IDX_W-1:0] res_idx_r;
  logic             res_new_r, res_full_r;
  logic [CNT_W-1:0] res_cnt_r;
  pt_t              res_cx_r, res_cy_r, res_cz_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_new_r, out_full_r;
  logic [CNT_W-1:0] out_cnt_r;
  pt_t              out_cx_r, out_cy_r, out_cz_r;

  logic [LDR_W-1:0]  ldr_q, ldr_wdata;
  logic [MEAN_W-1:0] mean_q, mean_wdata;
  logic              ldr_re, ldr_we, mean_re, mean_we;
  logic [AW-1:0]     mean_waddr;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [24:0] dx, dy, dz;
  mag_t ld_len, ld_bend, dlen, dbend;
  pt_t  lx, ly, lz, cur_c, cur_p;
  logic [CNT_W-1:0] mcnt;

  logic            sq_start, sq_done;
  logic [RT_W-1:0] sq_root;
  logic [SQ_W-1:0] sq_rad;
  logic             dv_start, dv_done;
  logic [NUM_W-1:0] dv_q;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_mag;
  pt_t  dv_val;
  logic [CW+IDX_W-1:0] idx_ext, used_ext;
  logic in_acc;
  logic tbl_room;

  assign in_ch.ready = (state_r == 5'(ST_IDLE));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tbl_room    = used_r < CW'(MAX_CLUSTERS);

  assign lx      = ldr_q[LDR_W-1 -: PT_W];
  assign ly      = ldr_q[LDR_W-PT_W-1 -: PT_W];
  assign lz      = ldr_q[LDR_W-2*PT_W-1 -: PT_W];
  assign ld_len  = ldr_q[2*PT_W-1 -: PT_W];
  assign ld_bend = ldr_q[PT_W-1:0];

  assign dx    = {px_r[PT_W-1], px_r} - {lx[PT_W-1], lx};
  assign dy    = {py_r[PT_W-1], py_r} - {ly[PT_W-1], ly};
  assign dz    = {pz_r[PT_W-1], pz_r} - {lz[PT_W-1], lz};
  assign dlen  = (len_r >= ld_len) ? len_r - ld_len : ld_len - len_r;
  assign dbend = (bend_r >= ld_bend) ? bend_r - ld_bend : ld_bend - bend_r;

  assign mcnt = mean_q[CNT_W-1:0];

  always_comb begin
    case (ax_r)
      2'd0: begin
        cur_c = mean_q[MEAN_W-1 -: PT_W];
        cur_p = px_r;
      end
      2'd1: begin
        cur_c = mean_q[MEAN_W-PT_W-1 -: PT_W];
        cur_p = py_r;
      end
      default: begin
        cur_c = mean_q[MEAN_W-2*PT_W-1 -: PT_W];
        cur_p = pz_r;
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      5'(ST_SQ0): begin
        mul_a = {{2{dx[24]}}, dx};
        mul_b = {{2{dx[24]}}, dx};
      end
      5'(ST_SQ1): begin
        mul_a = {{2{dy[24]}}, dy};
        mul_b = {{2{dy[24]}}, dy};
      end
      5'(ST_SQ2): begin
        mul_a = {{2{dz[24]}}, dz};
        mul_b = {{2{dz[24]}}, dz};
      end
      5'(ST_W0): begin
        mul_a = {11'd0, wd_r};
        mul_b = {1'b0, sq_root};
      end
      5'(ST_W1): begin
        mul_a = {11'd0, wl_r};
        mul_b = {3'd0, dlen};
      end
      5'(ST_W2): begin
        mul_a = {11'd0, wc_r};
        mul_b = {3'd0, dbend};
      end
      5'(ST_M0): begin
        mul_a = {{3{cur_c[PT_W-1]}}, cur_c};
        mul_b = {11'd0, n_r - 16'd1};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign num     = prod_r[NUM_W-1:0] + {{(NUM_W-PT_W){cur_p[PT_W-1]}}, cur_p};
  assign num_mag = num[NUM_W-1] ? -num : num;
  assign dv_val  = sign_r ? -dv_q[PT_W-1:0] : dv_q[PT_W-1:0];

  // last square is still in the product register when the root starts
  assign sq_rad   = acc_r[SQ_W-1:0] + prod_r[SQ_W-1:0];
  assign sq_start = (state_r == 5'(ST_SQ3));
  assign dv_start = (state_r == 5'(ST_M1));
  assign ldr_re   = (state_r == 5'(ST_RD));
  assign mean_re  = (state_r == 5'(ST_CMP));
  assign ldr_we   = (state_r == ST_NEW) && tbl_room;
  assign mean_we  = ldr_we || (state_r == ST_WR);
  assign mean_waddr = (state_r == ST_WR) ? idx_r[AW-1:0] : used_r[AW-1:0];
  assign ldr_wdata  = {px_r, py_r, pz_r, len_r, bend_r};
  assign mean_wdata = (state_r == ST_WR) ? {res_cx_r, res_cy_r, res_cz_r, n_r}
                                         : {px_r, py_r, pz_r, 16'd1};
  assign idx_ext  = {{IDX_W{1'b0}}, idx_r};
  assign used_ext = {{IDX_W{1'b0}}, used_r};

  wlc_ram #(.WIDTH(LDR_W), .DEPTH(MAX_CLUSTERS)) u_ldr_ram (
    .clk(clk), .we(ldr_we), .waddr(used_r[AW-1:0]), .wdata(ldr_wdata),
    .re(ldr_re), .raddr(idx_r[AW-1:0]), .rdata(ldr_q)
  );

  wlc_ram #(.WIDTH(MEAN_W), .DEPTH(MAX_CLUSTERS)) u_mean_ram (
    .clk(clk), .we(mean_we), .waddr(mean_waddr), .wdata(mean_wdata),
    .re(mean_re), .raddr(idx_r[AW-1:0]), .rdata(mean_q)
  );

  wlc_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  wlc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(num_mag), .divisor(n_r),
    .done(dv_done), .quotient(dv_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r  <= 16'd4096;
      wl_r  <= 16'd4096;
      wc_r  <= 16'd4096;
      thr_r <= 32'd1600;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WDIST:  wd_r  <= cfg_data[WGT_W-1:0];
        CFG_WLEN:   wl_r  <= cfg_data[WGT_W-1:0];
        CFG_WBEND:  wc_r  <= cfg_data[WGT_W-1:0];
        CFG_THRESH: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= 5'(ST_IDLE);
      used_r      <= '0;
      idx_r       <= '0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        5'(ST_IDLE): begin
          if (in_acc) begin
            px_r   <= in_ch.start_x;
            py_r   <= in_ch.start_y;
            pz_r   <= in_ch.start_z;
            len_r  <= in_ch.curve_length;
            bend_r <= in_ch.curve_bend;
            if (in_ch.first_in_set) begin
              used_r <= '0;
            end
            idx_r   <= '0;
            state_r <= 5'(ST_RD);
          end
        end
        5'(ST_RD): begin
          if (idx_r == used_r) begin
            state_r <= ST_NEW;
          end else begin
            state_r <= 5'(ST_SQ0);
          end
        end
        5'(ST_SQ0): state_r <= 5'(ST_SQ1);
        5'(ST_SQ1): begin
          acc_r   <= prod_r;
          state_r <= 5'(ST_SQ2);
        end
        5'(ST_SQ2): begin
          acc_r   <= acc_r + prod_r;
          state_r <= 5'(ST_SQ3);
        end
        5'(ST_SQ3): begin
          acc_r   <= acc_r + prod_r;
          state_r <= 5'(ST_SQRT);
        end
        5'(ST_SQRT): begin
          if (sq_done) begin
            state_r <= 5'(ST_W0);
          end
        end
        5'(ST_W0): state_r <= 5'(ST_W1);
        5'(ST_W1): begin
          acc_r   <= prod_r;
          state_r <= 5'(ST_W2);
        end
        5'(ST_W2): begin
          acc_r   <= acc_r + prod_r;
          state_r <= 5'(ST_W3);
        end
        5'(ST_W3): begin
          acc_r   <= acc_r + prod_r;
          state_r <= 5'(ST_CMP);
        end
        5'(ST_CMP): begin
          if (acc_r < {{(PRD_W-THR_W-12){1'b0}}, thr_r, 12'd0}) begin
            state_r <= 5'(ST_HWT);
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= 5'(ST_RD);
          end
        end
        5'(ST_HWT): begin
          n_r     <= (mcnt < CNT_MAX) ? mcnt + 16'd1 : mcnt;
          ax_r    <= 2'd0;
          state_r <= 5'(ST_M0);
        end
        5'(ST_M0): state_r <= 5'(ST_M1);
        5'(ST_M1): begin
          sign_r  <= num[NUM_W-1];
          state_r <= 5'(ST_MDIV);
        end
        5'(ST_MDIV): begin
          if (dv_done) begin
            case (ax_r)
              2'd0:    res_cx_r <= dv_val;
              2'd1:    res_cy_r <= dv_val;
              default: res_cz_r <= dv_val;
            endcase
            if (ax_r == 2'd2) begin
              state_r <= ST_WR;
            end else begin
              ax_r    <= ax_r + 2'd1;
              state_r <= 5'(ST_M0);
            end
          end
        end
        ST_WR: begin
          res_idx_r  <= idx_ext[IDX_W-1:0];
          res_new_r  <= 1'b0;
          res_full_r <= 1'b0;
          res_cnt_r  <= n_r;
          state_r    <= ST_FIN;
        end
        ST_NEW: begin
          if (tbl_room) begin
            res_idx_r  <= used_ext[IDX_W-1:0];
            res_new_r  <= 1'b1;
            res_full_r <= 1'b0;
            res_cnt_r  <= 16'd1;
            res_cx_r   <= px_r;
            res_cy_r   <= py_r;
            res_cz_r   <= pz_r;
            used_r     <= used_r + CW'(1);
          end else begin
            res_idx_r  <= '0;
            res_new_r  <= 1'b0;
            res_full_r <= 1'b1;
            res_cnt_r  <= '0;
            res_cx_r   <= '0;
            res_cy_r   <= '0;
            res_cz_r   <= '0;
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= res_idx_r;
            out_new_r   <= res_new_r;
            out_full_r  <= res_full_r;
            out_cnt_r   <= res_cnt_r;
            out_cx_r    <= res_cx_r;
            out_cy_r    <= res_cy_r;
            out_cz_r    <= res_cz_r;
            state_r     <= 5'(ST_IDLE);
          end
        end
        default: state_r <= 5'(ST_IDLE);
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cluster_index = out_idx_r;
  assign out_ch.created_new   = out_new_r;
  assign out_ch.table_full    = out_full_r;
  assign out_ch.member_count  = out_cnt_r;
  assign out_ch.center_x      = out_cx_r;
  assign out_ch.center_y      = out_cy_r;
  assign out_ch.center_z      = out_cz_r;
endmodule

// ----- hw/rtl/wlc_checker.sv -----
// port-level checker for the leader clustering block, bound to the top
`include "weighted_leader_clustering_assert.svh"

module wlc_checker import wlc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             created_new,
  input logic             table_full,
  input logic [IDX_W-1:0] cluster_index,
  input logic [CNT_W-1:0] member_count
);
  // one request in flight: no new item right after one is taken
  `WLC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // overflow result carries no slot and no members
  `WLC_ASSERT_NOW(a_full_clear, out_valid && table_full,
    !created_new && cluster_index == '0 && member_count == '0)
  // a new cluster starts with its leader only
  `WLC_ASSERT_NOW(a_new_one, out_valid && created_new, member_count == 16'd1 && !table_full)
  // joined clusters always hold at least two members
  `WLC_ASSERT_NOW(a_join_cnt, out_valid && !created_new && !table_full, member_count > 16'd1)
  // a stalled result stays up
  `WLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind weighted_leader_clustering wlc_checker u_wlc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .created_new(out_ch.created_new), .table_full(out_ch.table_full),
  .cluster_index(out_ch.cluster_index), .member_count(out_ch.member_count)
);

// ----- bench/testbench.sv -----
// self-checking bench for the weighted leader clustering block
`timescale 1ns / 100ps

module testbench;
  import wlc_pkg::*;

  localparam int SLOTS = 64;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic first;
    pt_t  x;
    pt_t  y;
    pt_t  z;
    mag_t len;
    mag_t bend;
  } curve_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             created;
    logic             full;
    logic [CNT_W-1:0] count;
    pt_t              cx;
    pt_t              cy;
    pt_t              cz;
  } cluster_res_t;

  typedef struct {
    curve_t       it;
    bit           typed;
    cluster_res_t res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  wlc_in_if  in_ch ();
  wlc_out_if out_ch ();

  weighted_leader_clustering dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the cluster table and registers
  logic [WGT_W-1:0] w_dist, w_len, w_bend;
  logic [THR_W-1:0] thresh;
  pt_t  ldr_x [SLOTS];
  pt_t  ldr_y [SLOTS];
  pt_t  ldr_z [SLOTS];
  mag_t ldr_len [SLOTS];
  mag_t ldr_bend [SLOTS];
  pt_t  ctr_x [SLOTS];
  pt_t  ctr_y [SLOTS];
  pt_t  ctr_z [SLOTS];
  int unsigned count_of [SLOTS];
  int unsigned used;

  cluster_res_t pending[$];
  int failures = 0;
  int n_items = 0, n_results = 0, n_joins = 0, n_created = 0, n_full = 0;
  int s_idle = 0, r_idle = 0;
  int hold_asks = 0, hold_done = 0, hold_left = 0;
  int quiet = 0;
  curve_t pool[8];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned gap(longint a, longint b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic pt_t running_mean(pt_t c, pt_t p, int unsigned n);
    longint num;
    num = longint'(c) * longint'(n - 1) + longint'(p);
    return pt_t'(num / longint'(n));
  endfunction

  // scan in creation order, join the first close leader, open a slot or report overflow
  function automatic cluster_res_t cluster_item(curve_t it);
    cluster_res_t r;
    longint unsigned limit, d2, score;
    bit found;
    int hit;
    r = '0;
    found = 0;
    hit = 0;
    limit = longint'(thresh) << 12;
    if (it.first) used = 0;
    for (int i = 0; i < used && !found; i++) begin
      d2 = gap(it.x, ldr_x[i]) ** 2 + gap(it.y, ldr_y[i]) ** 2 + gap(it.z, ldr_z[i]) ** 2;
      score = longint'(w_dist) * root_floor(d2)
            + longint'(w_len) * gap(it.len, ldr_len[i])
            + longint'(w_bend) * gap(it.bend, ldr_bend[i]);
      if (score < limit) begin
        found = 1;
        hit = i;
      end
    end
    if (found) begin
      if (count_of[hit] < 65535) count_of[hit]++;
      ctr_x[hit] = running_mean(ctr_x[hit], it.x, count_of[hit]);
      ctr_y[hit] = running_mean(ctr_y[hit], it.y, count_of[hit]);
      ctr_z[hit] = running_mean(ctr_z[hit], it.z, count_of[hit]);
    end else if (used < SLOTS) begin
      hit = used++;
      ldr_x[hit] = it.x;
      ldr_y[hit] = it.y;
      ldr_z[hit] = it.z;
      ldr_len[hit] = it.len;
      ldr_bend[hit] = it.bend;
      ctr_x[hit] = it.x;
      ctr_y[hit] = it.y;
      ctr_z[hit] = it.z;
      count_of[hit] = 1;
      r.created = 1'b1;
    end else begin
      r.full = 1'b1;
      return r;
    end
    r.idx = hit[IDX_W-1:0];
    r.count = count_of[hit][CNT_W-1:0];
    r.cx = ctr_x[hit];
    r.cy = ctr_y[hit];
    r.cz = ctr_z[hit];
    return r;
  endfunction

  function automatic curve_t mk(int f, int x, int y, int z, int l, int b);
    curve_t c;
    c.first = f[0];
    c.x = pt_t'(x);
    c.y = pt_t'(y);
    c.z = pt_t'(z);
    c.len = mag_t'(l);
    c.bend = mag_t'(b);
    return c;
  endfunction

  function automatic curve_t any_curve();
    return mk($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // mostly jittered copies of a few seeds so that joins happen, some noise
  function automatic curve_t next_curve();
    curve_t c;
    int k;
    if ($urandom_range(99) < 10) return any_curve();
    k = $urandom_range(7);
    if ($urandom_range(99) < 5) pool[k] = any_curve();
    c = pool[k];
    c.first = ($urandom_range(24) == 0);
    c.x = c.x + pt_t'(int'($urandom_range(40)) - 20);
    c.y = c.y + pt_t'(int'($urandom_range(40)) - 20);
    c.z = c.z + pt_t'(int'($urandom_range(40)) - 20);
    c.len = c.len + mag_t'(int'($urandom_range(600)) - 300);
    c.bend = c.bend + mag_t'(int'($urandom_range(600)) - 300);
    return c;
  endfunction

  task automatic send(curve_t it, bit typed = 0, cluster_res_t res = '0);
    cluster_res_t predicted;
    while ($urandom_range(99) < s_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_in_set <= it.first;
    in_ch.start_x <= it.x;
    in_ch.start_y <= it.y;
    in_ch.start_z <= it.z;
    in_ch.curve_length <= it.len;
    in_ch.curve_bend <= it.bend;
    do @(posedge clk); while (!in_ch.ready);
    predicted = cluster_item(it);
    pending.push_back(typed ? res : predicted);
    n_items++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // drives one write; the caller drops the enable
  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_WDIST:  w_dist = val[WGT_W-1:0];
      CFG_WLEN:   w_len = val[WGT_W-1:0];
      CFG_WBEND:  w_bend = val[WGT_W-1:0];
      CFG_THRESH: thresh = val;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [WGT_W-1:0] wd, logic [WGT_W-1:0] wl,
                         logic [WGT_W-1:0] wb, logic [THR_W-1:0] th);
    drain();
    set_reg(CFG_WDIST, CFG_DW'(wd));
    set_reg(CFG_WLEN, CFG_DW'(wl));
    set_reg(CFG_WBEND, CFG_DW'(wb));
    set_reg(CFG_THRESH, th);
    cfg_we <= 1'b0;
  endtask

  // receiver: random back-pressure, long hold on request, result check
  always @(posedge clk) begin
    cluster_res_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cluster_index, out_ch.created_new, out_ch.table_full,
                out_ch.member_count, out_ch.center_x, out_ch.center_y, out_ch.center_z};
        if (pending.size() == 0) begin
          $display("%0t: result with nothing expected: idx %0d new %0b full %0b", $time,
                   got.idx, got.created, got.full);
          failures++;
        end else begin
          want = pending.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp idx %0d new %0b full %0b cnt %0d c %0d %0d %0d",
                     $time, want.idx, want.created, want.full, want.count,
                     want.cx, want.cy, want.cz);
            $display("%0t:          act idx %0d new %0b full %0b cnt %0d c %0d %0d %0d",
                     $time, got.idx, got.created, got.full, got.count,
                     got.cx, got.cy, got.cz);
            failures++;
          end
        end
        n_results++;
        if (got.full) n_full++;
        else if (got.created) n_created++;
        else n_joins++;
      end
      if (hold_done != hold_asks) begin
        hold_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= r_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    in_ch.valid = 1'b0;
    in_ch.first_in_set = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.start_z = '0;
    in_ch.curve_length = '0;
    in_ch.curve_bend = '0;
    w_dist = 16'd4096;
    w_len = 16'd4096;
    w_bend = 16'd4096;
    thresh = 32'd1600;
    used = 0;
    foreach (pool[k]) pool[k] = mk(0, $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                                   $urandom_range(4000) - 2000, $urandom_range(9000),
                                   $urandom_range(9000));

    plan.push_back('{mk(1, 0, 0, 0, 0, 0), 1, '{0, 1, 0, 1, 0, 0, 0}});
    plan.push_back('{mk(0, 10, 0, 0, 0, 0), 0, '0});
    plan.push_back('{mk(1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF), 1,
                     '{0, 1, 0, 1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF}});
    plan.push_back('{mk(0, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 0), 1,
                     '{1, 1, 0, 1, 24'h800000, 24'h7FFFFF, 24'h800000}});
    // bend gap right at the threshold does not join, one below does
    plan.push_back('{mk(0, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 1600), 0, '0});
    plan.push_back('{mk(0, 24'h800000, 24'h7FFFFF, 24'h800000, 0, 1599), 0, '0});
    plan.push_back('{mk(1, -16, -16, -16, 5, 5), 1, '{0, 1, 0, 1, -16, -16, -16}});
    // negative means truncate toward zero
    plan.push_back('{mk(0, -17, -16, -16, 5, 5), 0, '0});
    plan.push_back('{mk(0, -15, -17, -14, 6, 4), 0, '0});
    plan.push_back('{mk(0, 1590, -16, -16, 5, 5), 0, '0});
    plan.push_back('{mk(0, -16, -16, -16, 1600, 5), 0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    s_idle = 11;
    r_idle = 52;
    foreach (plan[i]) send(plan[i].it, plan[i].typed, plan[i].res);
    for (int i = 0; i < 110; i++) begin
      if (i == 40) hold_asks++;
      if (i == 80) drain();
      send(next_curve());
    end

    // nothing can match: fill the table and overflow it
    s_idle = 52;
    r_idle = 11;
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
    send(mk(1, $urandom, $urandom, $urandom, $urandom, $urandom));
    for (int i = 0; i < 69; i++) begin
      curve_t c;
      c = any_curve();
      c.first = 1'b0;
      send(c);
    end

    // zero weights: every item joins the first cluster
    set_all(16'd0, 16'd0, 16'd0, 32'd1);
    for (int i = 0; i < 40; i++) begin
      curve_t c;
      c = any_curve();
      c.first = (i == 0);
      send(c);
    end

    s_idle = 0;
    r_idle = 0;
    set_all(16'($urandom), 16'($urandom), 16'($urandom), 32'hFFFFFFFF);
    for (int i = 0; i < 40; i++) send(next_curve());

    for (int p = 0; p < 4; p++) begin
      set_all(16'($urandom_range(8192)), 16'($urandom_range(8192)),
              16'($urandom_range(8192)), $urandom_range(40000));
      for (int i = 0; i < 30; i++) send(next_curve());
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items, %0d results: %0d joins, %0d new clusters, %0d overflows",
             n_items, n_results, n_joins, n_created, n_full);
    $display("weights and threshold swept over zero, full scale and random settings");
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
